@@ rtl/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the line sensor position tracker.
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int NUM_SENSORS = 8;
	localparam int IDX_W       = 3;
	localparam int ACT_W       = 4;
	localparam int SAMPLE_W    = 10;
	localparam int RES_W       = 12;
	localparam int CALFR_W     = 8;
	localparam int POS_W       = 15;
	localparam int TOTAL_W     = 30;
	localparam int WEIGHT_W    = 15;
	localparam int DIV_NUM_W   = 30;
	localparam int DIV_DEN_W   = 15;
	localparam int DIV_CNT_W   = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [RES_W-1:0] ON_LINE_LEVEL = RES_W'(70);
	localparam logic [RES_W-1:0] NOISE_LEVEL   = RES_W'(50);

	localparam logic [ACT_W-1:0]   ACT_RESET   = ACT_W'(8);
	localparam logic [RES_W-1:0]   RES_RESET   = RES_W'(1000);
	localparam logic [CALFR_W-1:0] CALFR_RESET = CALFR_W'(16);

	localparam logic OP_CALIBRATE = 1'b1;
	localparam logic KIND_POSITION = 1'b0;
	localparam logic KIND_CALIBRATE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_SENSORS = 2'd0,
		CFG_RESOLUTION     = 2'd1,
		CFG_INVERTED       = 2'd2,
		CFG_CAL_FRAMES     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_NORM,
		DIV_RESCALE,
		DIV_CENTROID
	} div_sel_t;

	typedef struct packed {
		logic     latch;
		logic     cal_fold;
		logic     cal_commit;
		logic     load_cal;
		logic     pos_start;
		logic     norm_wr;
		logic     scale_wr;
		logic     acc;
		logic     div_start;
		div_sel_t div_sel;
		logic     fin_off;
		logic     fin_wr;
		logic     load_pos;
	} cmd_t;

	typedef struct packed {
		logic is_end;
		logic is_cal;
		logic gather_full;
		logic cnt_last;
		logic n_zero;
		logic r_zero;
		logic div_done;
		logic offline;
	} status_t;

endpackage

@@ rtl/lsp_div.sv @@
// ----------------------------------------------------------------------------
// lsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lsp_pkg::DIV_NUM_W-1:0]   num,
	input  logic [lsp_pkg::DIV_DEN_W-1:0]   den,
	output logic                            done,
	output logic [lsp_pkg::DIV_NUM_W-1:0]   quot
);

	logic [lsp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [lsp_pkg::DIV_DEN_W-1:0] rem_q;
	logic [lsp_pkg::DIV_NUM_W-1:0] quot_q;
	logic [lsp_pkg::DIV_DEN_W:0]   shifted;
	logic [lsp_pkg::DIV_DEN_W:0]   rem_next;
	logic                          ge;

	always_comb begin
		shifted  = {rem_q, quot_q[lsp_pkg::DIV_NUM_W-1]};
		ge       = shifted >= {1'b0, den};
		rem_next = ge ? shifted - {1'b0, den} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= lsp_pkg::DIV_CNT_W'(lsp_pkg::DIV_NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == lsp_pkg::DIV_CNT_W'(1));
			end
		end
	end

	// shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
		end else if (cnt_q != '0) begin
			rem_q  <= rem_next[lsp_pkg::DIV_DEN_W-1:0];
			quot_q <= {quot_q[lsp_pkg::DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/lsp_datapath.sv @@
// ----------------------------------------------------------------------------
// lsp_datapath
// Configuration, sample and limit storage, normalize/centroid arithmetic.
// ----------------------------------------------------------------------------
module lsp_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lsp_pkg::cmd_t                    cmd,
	output lsp_pkg::status_t                 st,
	input  logic                             cfg_valid,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             operation,
	input  logic [lsp_pkg::IDX_W-1:0]        sensor_index,
	input  logic [lsp_pkg::SAMPLE_W-1:0]     sensor_value,
	output logic                             result_kind,
	output logic [lsp_pkg::POS_W-1:0]        line_position,
	output logic                             on_line,
	output logic                             calibration_done
);

	logic [lsp_pkg::ACT_W-1:0]   act_q;
	logic [lsp_pkg::RES_W-1:0]   res_q;
	logic                        inv_q;
	logic [lsp_pkg::CALFR_W-1:0] calfr_q;

	logic [lsp_pkg::SAMPLE_W-1:0] samples_q [lsp_pkg::NUM_SENSORS];
	logic [lsp_pkg::SAMPLE_W-1:0] byp       [lsp_pkg::NUM_SENSORS];
	logic [lsp_pkg::SAMPLE_W-1:0] cmin_q    [lsp_pkg::NUM_SENSORS];
	logic [lsp_pkg::SAMPLE_W-1:0] cmax_q    [lsp_pkg::NUM_SENSORS];
	logic [lsp_pkg::SAMPLE_W-1:0] gmin_q    [lsp_pkg::NUM_SENSORS];
	logic [lsp_pkg::SAMPLE_W-1:0] gmax_q    [lsp_pkg::NUM_SENSORS];
	logic [lsp_pkg::CALFR_W-1:0]  fg_q;
	logic [lsp_pkg::RES_W-1:0]    norm_q    [lsp_pkg::NUM_SENSORS];

	logic [lsp_pkg::IDX_W-1:0]    last_idx;
	logic [lsp_pkg::IDX_W-1:0]    cnt_q;
	logic [lsp_pkg::RES_W-1:0]    lo_q, hi_q, v_q;
	logic [lsp_pkg::POS_W-1:0]    pos_q, span_q, last_q, fpos_q;
	logic [lsp_pkg::TOTAL_W-1:0]  total_q;
	logic [lsp_pkg::WEIGHT_W-1:0] weight_q;
	logic                         seen_q, fon_q;

	logic [lsp_pkg::SAMPLE_W-1:0] n_v, n_a, n_b;
	logic [lsp_pkg::RES_W-1:0]    r_v, n_res, s_res;
	logic [lsp_pkg::DIV_NUM_W-1:0] n_num, r_num, div_num, quot;
	logic [lsp_pkg::DIV_DEN_W-1:0] n_den, r_den, div_den;
	logic                          n_zero, r_zero, div_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= lsp_pkg::ACT_RESET;
			res_q   <= lsp_pkg::RES_RESET;
			inv_q   <= 1'b0;
			calfr_q <= lsp_pkg::CALFR_RESET;
		end else if (cfg_valid) begin
			case (lsp_pkg::cfg_idx_t'(cfg_index))
				lsp_pkg::CFG_ACTIVE_SENSORS: act_q   <= cfg_data[lsp_pkg::ACT_W-1:0];
				lsp_pkg::CFG_RESOLUTION:     res_q   <= cfg_data[lsp_pkg::RES_W-1:0];
				lsp_pkg::CFG_INVERTED:       inv_q   <= cfg_data[0];
				lsp_pkg::CFG_CAL_FRAMES:     calfr_q <= cfg_data[lsp_pkg::CALFR_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the sensor count to 2..NUM_SENSORS
	always_comb begin
		if (act_q < lsp_pkg::ACT_W'(2))
			last_idx = lsp_pkg::IDX_W'(1);
		else if (act_q > lsp_pkg::ACT_W'(lsp_pkg::NUM_SENSORS))
			last_idx = lsp_pkg::IDX_W'(lsp_pkg::NUM_SENSORS - 1);
		else
			last_idx = lsp_pkg::IDX_W'(act_q - lsp_pkg::ACT_W'(1));
	end

	always_comb begin
		for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++)
			byp[i] = (sensor_index == lsp_pkg::IDX_W'(i)) ? sensor_value : samples_q[i];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch)
			samples_q[sensor_index] <= sensor_value;
	end

	// calibration gathering and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++) begin
				cmin_q[i] <= '1;
				cmax_q[i] <= '0;
				gmin_q[i] <= '1;
				gmax_q[i] <= '0;
			end
			fg_q <= '0;
		end else if (cmd.cal_fold) begin
			for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++) begin
				if (lsp_pkg::IDX_W'(i) <= last_idx) begin
					if (byp[i] < gmin_q[i]) gmin_q[i] <= byp[i];
					if (byp[i] > gmax_q[i]) gmax_q[i] <= byp[i];
				end
			end
			fg_q <= fg_q + 1'b1;
		end else if (cmd.cal_commit) begin
			for (int i = 0; i < lsp_pkg::NUM_SENSORS; i++) begin
				if (lsp_pkg::IDX_W'(i) <= last_idx) begin
					cmin_q[i] <= gmin_q[i];
					cmax_q[i] <= gmax_q[i];
				end
				gmin_q[i] <= '1;
				gmax_q[i] <= '0;
			end
			fg_q <= '0;
		end
	end

	// normalize and rescale pass operands
	always_comb begin
		n_v    = samples_q[cnt_q];
		n_a    = (n_v < cmin_q[cnt_q]) ? n_v : cmin_q[cnt_q];
		n_b    = (n_v > cmax_q[cnt_q]) ? n_v : cmax_q[cnt_q];
		n_zero = (n_b == n_a);
		n_num  = lsp_pkg::DIV_NUM_W'(n_v - n_a) * lsp_pkg::DIV_NUM_W'(res_q);
		n_den  = lsp_pkg::DIV_DEN_W'(n_b - n_a);
		n_res  = n_zero ? '0 : quot[lsp_pkg::RES_W-1:0];
		r_v    = norm_q[cnt_q];
		r_zero = (hi_q <= lo_q);
		r_num  = lsp_pkg::DIV_NUM_W'(r_v - lo_q) * lsp_pkg::DIV_NUM_W'(res_q);
		r_den  = lsp_pkg::DIV_DEN_W'(hi_q - lo_q);
		s_res  = r_zero ? '0 : quot[lsp_pkg::RES_W-1:0];
	end

	always_comb begin
		case (cmd.div_sel)
			lsp_pkg::DIV_NORM: begin
				div_num = n_num;
				div_den = n_den;
			end
			lsp_pkg::DIV_RESCALE: begin
				div_num = r_num;
				div_den = r_den;
			end
			default: begin
				div_num = total_q;
				div_den = weight_q;
			end
		endcase
	end

	lsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else begin
			if (cmd.pos_start)
				cnt_q <= '0;
			else if (cmd.norm_wr || cmd.acc)
				cnt_q <= (cnt_q == last_idx) ? '0 : cnt_q + 1'b1;
			if (cmd.fin_wr)
				last_q <= quot[lsp_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_start) begin
			lo_q     <= res_q;
			hi_q     <= '0;
			pos_q    <= '0;
			total_q  <= '0;
			weight_q <= '0;
			seen_q   <= 1'b0;
		end
		if (cmd.norm_wr) begin
			norm_q[cnt_q] <= n_res;
			if (n_res < lo_q) lo_q <= n_res;
			if (n_res > hi_q) hi_q <= n_res;
		end
		if (cmd.scale_wr)
			v_q <= inv_q ? res_q - s_res : s_res;
		if (cmd.acc) begin
			if (v_q > lsp_pkg::NOISE_LEVEL) begin
				total_q  <= total_q + lsp_pkg::TOTAL_W'(v_q) * lsp_pkg::TOTAL_W'(pos_q);
				weight_q <= weight_q + lsp_pkg::WEIGHT_W'(v_q);
			end
			if (v_q > lsp_pkg::ON_LINE_LEVEL)
				seen_q <= 1'b1;
			pos_q <= pos_q + lsp_pkg::POS_W'(res_q);
			if (cnt_q == last_idx)
				span_q <= pos_q;
		end
		if (cmd.fin_off) begin
			fpos_q <= (last_q < (span_q >> 1)) ? '0 : span_q;
			fon_q  <= 1'b0;
		end
		if (cmd.fin_wr) begin
			fpos_q <= quot[lsp_pkg::POS_W-1:0];
			fon_q  <= 1'b1;
		end
		if (cmd.load_cal) begin
			result_kind      <= lsp_pkg::KIND_CALIBRATE;
			line_position    <= '0;
			on_line          <= 1'b0;
			calibration_done <= st.gather_full;
		end
		if (cmd.load_pos) begin
			result_kind      <= lsp_pkg::KIND_POSITION;
			line_position    <= fpos_q;
			on_line          <= fon_q;
			calibration_done <= 1'b0;
		end
	end

	always_comb begin
		st.is_end      = (sensor_index == last_idx);
		st.is_cal      = (operation == lsp_pkg::OP_CALIBRATE);
		st.gather_full = !(fg_q < calfr_q);
		st.cnt_last    = (cnt_q == last_idx);
		st.n_zero      = n_zero;
		st.r_zero      = r_zero;
		st.div_done    = div_done;
		st.offline     = !seen_q || (weight_q == '0);
	end

endmodule

@@ rtl/lsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsp_ctrl
// Frame sequencer: handshakes and the normalize/rescale/centroid passes.
// ----------------------------------------------------------------------------
module lsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  lsp_pkg::status_t  st,
	output lsp_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_N_ISSUE, ST_N_WAIT, ST_R_ISSUE, ST_R_WAIT,
		ST_ACC, ST_F_ISSUE, ST_F_WAIT, ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free, accept;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (st.is_end && st.is_cal && !out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd         = '0;
		cmd.div_sel = lsp_pkg::DIV_NORM;
		state_d     = state_q;
		cmd.latch   = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept && st.is_end) begin
					if (st.is_cal) begin
						cmd.load_cal   = 1'b1;
						cmd.cal_commit = st.gather_full;
						cmd.cal_fold   = !st.gather_full;
					end else begin
						cmd.pos_start = 1'b1;
						state_d       = ST_N_ISSUE;
					end
				end
			end
			ST_N_ISSUE: begin
				if (st.n_zero) begin
					cmd.norm_wr = 1'b1;
					if (st.cnt_last) state_d = ST_R_ISSUE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_N_WAIT;
				end
			end
			ST_N_WAIT: begin
				if (st.div_done) begin
					cmd.norm_wr = 1'b1;
					state_d     = st.cnt_last ? ST_R_ISSUE : ST_N_ISSUE;
				end
			end
			ST_R_ISSUE: begin
				cmd.div_sel = lsp_pkg::DIV_RESCALE;
				if (st.r_zero) begin
					cmd.scale_wr = 1'b1;
					state_d      = ST_ACC;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_R_WAIT;
				end
			end
			ST_R_WAIT: begin
				cmd.div_sel = lsp_pkg::DIV_RESCALE;
				if (st.div_done) begin
					cmd.scale_wr = 1'b1;
					state_d      = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = st.cnt_last ? ST_F_ISSUE : ST_R_ISSUE;
			end
			ST_F_ISSUE: begin
				cmd.div_sel = lsp_pkg::DIV_CENTROID;
				if (st.offline) begin
					cmd.fin_off = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_F_WAIT;
				end
			end
			ST_F_WAIT: begin
				cmd.div_sel = lsp_pkg::DIV_CENTROID;
				if (st.div_done) begin
					cmd.fin_wr = 1'b1;
					state_d    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_pos = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_cal || cmd.load_pos)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_start_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_N_WAIT || state_q == ST_R_WAIT ||
			state_q == ST_F_WAIT))
		else $error("divider started outside an issue step");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == ST_N_WAIT || state_q == ST_R_WAIT ||
			state_q == ST_F_WAIT))
		else $error("divider finished while no pass waits on it");

	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_cal || cmd.load_pos))
		else $error("result word raised without a load");

endmodule

@@ rtl/line_sensor_position_tracker_core.sv @@
// ----------------------------------------------------------------------------
// line_sensor_position_tracker_core
// Per-sensor readings in, one calibration or position result per frame out.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in       in_valid/in_stall   operation, sensor_index, sensor_value
//  out      out_valid/out_stall result_kind, line_position, on_line,
//                               calibration_done
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
//  A word that does not end a frame is taken whenever the core is idle; a
//  calibration frame end also waits for a free result register. A position
//  frame end runs three passes on one shared 30-bit divider, for n sensors:
//  up to n normalize divisions, up to n rescale divisions plus an accumulate
//  step per sensor, then at most one centroid division; input stalls meanwhile.
//  Reset clears limits, gathering count and last position; no clearing pass.
//  While a result waits in its register, only a calibration frame end stalls.
// ----------------------------------------------------------------------------
module line_sensor_position_tracker_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [lsp_pkg::IDX_W-1:0]        sensor_index,
	input  logic [lsp_pkg::SAMPLE_W-1:0]     sensor_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             result_kind,
	output logic [lsp_pkg::POS_W-1:0]        line_position,
	output logic                             on_line,
	output logic                             calibration_done
);

	lsp_pkg::cmd_t    cmd;
	lsp_pkg::status_t st;

	// configuration is to be written only while idle; the block does not enforce this, so always take it
	assign cfg_ready = 1'b1;

	// sequencer: handshakes and pass order
	lsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// storage and arithmetic
	lsp_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.sensor_index     (sensor_index),
		.sensor_value     (sensor_value),
		.result_kind      (result_kind),
		.line_position    (line_position),
		.on_line          (on_line),
		.calibration_done (calibration_done)
	);

endmodule
